// ===== src/brc_pkg.sv =====
// Shared types and codes for the resource request checker.
package brc_pkg;

  localparam logic [2:0] MODE_LOAD_ALLOC = 3'd0;
  localparam logic [2:0] MODE_LOAD_NEED  = 3'd1;
  localparam logic [2:0] MODE_LOAD_AVAIL = 3'd2;
  localparam logic [2:0] MODE_REQUEST    = 3'd3;
  localparam logic [2:0] MODE_CHECK      = 3'd4;

  localparam logic [1:0] STATUS_SAFE    = 2'd0;
  localparam logic [1:0] STATUS_UNSAFE  = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  localparam logic CFG_NUM_PROCESSES = 1'b0;
  localparam logic CFG_NUM_RESOURCES = 1'b1;

  // Command handed from the front end to the execution engine.
  typedef struct packed {
    logic       is_check;
    logic [2:0] mode;
    logic [3:0] process;
    logic [2:0] resource;
    logic [15:0] amount;
  } brc_cmd_t;

endpackage

// ===== src/brc_front.sv =====
// Front end: takes input items, drops ones that give no effect, queues commands.
module brc_front import brc_pkg::*; #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [3:0]  process,
  input  logic [2:0]  resource,
  input  logic [15:0] amount,
  output logic        cmd_valid,
  input  logic        cmd_take,
  output brc_cmd_t    cmd
);

  localparam int DEPTH = 4;

  brc_cmd_t q [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic       keep, push, pop;

  always_comb begin
    keep = 1'b0;
    if (mode == MODE_CHECK) begin
      keep = 1'b1;
    end else if (mode < MODE_CHECK) begin
      keep = (32'(process) < MAX_PROCESSES) && (32'(resource) < MAX_RESOURCES);
    end
  end

  assign in_stall  = (fill == 3'(DEPTH));
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (fill != 3'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{is_check: (mode == MODE_CHECK), mode: mode, process: process,
                     resource: resource, amount: amount};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== src/brc_engine.sv =====
// Back end: matrix storage, request check, safety scan and rollback sequencer.
module brc_engine import brc_pkg::*; #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  num_processes,
  input  logic [3:0]  num_resources,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  brc_cmd_t    cmd,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  finished_count
);

  localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam int ENTRIES = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_CHK    = 9'b000000100,
    S_APPLY  = 9'b000001000,
    S_SINIT  = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_ADD    = 9'b001000000,
    S_UNDO   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  // Matrices as memories, accessed one element at a time.
  logic [COUNT_WIDTH-1:0] alloc_mem [ENTRIES];
  logic [COUNT_WIDTH-1:0] need_mem  [ENTRIES];
  logic [COUNT_WIDTH-1:0] avail   [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] req_buf [MAX_RESOURCES];
  logic [COUNT_WIDTH-1:0] work    [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] fin;

  logic [AW-1:0] clr_addr;
  logic [PW-1:0] proc_r, scan_p;
  logic [RW-1:0] res_r;
  logic [CW-1:0] count, pass, np;
  logic [RW:0]   nr;
  logic          fits, is_req, seen;
  logic [COUNT_WIDTH-1:0] alloc_rd, need_rd;
  logic [1:0] stat_r;

  always_comb begin
    np = (num_processes == 5'd0) ? CW'(1)
       : (32'(num_processes) > MAX_PROCESSES) ? CW'(MAX_PROCESSES) : CW'(num_processes);
    nr = (num_resources == 4'd0) ? (RW+1)'(1)
       : (32'(num_resources) > MAX_RESOURCES) ? (RW+1)'(MAX_RESOURCES)
       : (RW+1)'(num_resources);
  end

  function automatic logic [AW-1:0] addr(input logic [PW-1:0] p, input logic [RW-1:0] r);
    addr = AW'(32'(p) * MAX_RESOURCES + 32'(r));
  endfunction

  logic [AW-1:0] rd_addr;
  logic          last_res;
  logic [COUNT_WIDTH:0] wsum;
  logic [COUNT_WIDTH-1:0] avail_rd, req_rd, work_rd;

  assign last_res = ((RW+1)'(res_r) == nr - (RW+1)'(1));
  assign avail_rd = avail[res_r];
  assign req_rd   = req_buf[res_r];
  assign work_rd  = work[res_r];
  assign wsum     = {1'b0, work_rd} + {1'b0, alloc_rd};

  // Read address selection: one element at proc_r/res_r, or at scan_p/res_r in scan and add.
  always_comb begin
    rd_addr = addr(proc_r, res_r);
    if (state == S_SCAN || state == S_ADD) rd_addr = addr(scan_p, res_r);
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign out_valid = (state == S_OUT);
  assign status = stat_r;
  assign finished_count = 5'(count);

  // Reads are registered: an element step uses the registered read data.
  logic [AW-1:0] nxt_addr;
  logic [PW-1:0] nxt_p;
  logic [RW-1:0] nxt_r;
  always_ff @(posedge clk) begin
    alloc_rd <= alloc_mem[nxt_addr];
    need_rd  <= need_mem[nxt_addr];
  end
  assign nxt_addr = addr(nxt_p, nxt_r);

  // Flow: each element step has an address phase, then a use phase, tracked by seen.
  always_comb begin
    nxt_p = (state == S_SCAN || state == S_ADD || state == S_SINIT) ? scan_p : proc_r;
    nxt_r = res_r;
  end

  logic [AW-1:0] wr_addr;
  assign wr_addr = rd_addr;

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      alloc_mem[clr_addr] <= '0;
      need_mem[clr_addr]  <= '0;
    end else if (state == S_IDLE && cmd_take && !cmd.is_check) begin
      if (cmd.mode == MODE_LOAD_ALLOC)
        alloc_mem[addr(PW'(cmd.process), RW'(cmd.resource))] <= COUNT_WIDTH'(cmd.amount);
      if (cmd.mode == MODE_LOAD_NEED)
        need_mem[addr(PW'(cmd.process), RW'(cmd.resource))] <= COUNT_WIDTH'(cmd.amount);
    end else if (state == S_APPLY && seen) begin
      alloc_mem[wr_addr] <= alloc_rd + req_rd;
      need_mem[wr_addr]  <= need_rd - req_rd;
    end else if (state == S_UNDO && seen) begin
      alloc_mem[wr_addr] <= alloc_rd - req_rd;
      need_mem[wr_addr]  <= need_rd + req_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      for (int j = 0; j < MAX_RESOURCES; j++) avail[j] <= '0;
      fin      <= '0;
      count    <= '0;
      stat_r   <= STATUS_SAFE;
      seen     <= 1'b0;
      proc_r   <= '0;
      res_r    <= '0;
      scan_p   <= '0;
      pass     <= '0;
      fits     <= 1'b1;
      is_req   <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == ENTRIES - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          seen <= 1'b0;
          if (cmd_take) begin
            proc_r <= PW'(cmd.process);
            res_r  <= '0;
            if (cmd.is_check) begin
              is_req <= 1'b0;
              state  <= S_SINIT;
            end else begin
              case (cmd.mode)
                MODE_LOAD_AVAIL: avail[RW'(cmd.resource)] <= COUNT_WIDTH'(cmd.amount);
                MODE_REQUEST: begin
                  req_buf[RW'(cmd.resource)] <= COUNT_WIDTH'(cmd.amount);
                  if ((RW+1)'(cmd.resource) == nr - (RW+1)'(1)) begin
                    if (CW'(cmd.process) >= np) begin
                      stat_r <= STATUS_REFUSED;
                      count  <= '0;
                      state  <= S_OUT;
                    end else begin
                      fits  <= 1'b1;
                      state <= S_CHK;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_CHK: begin
          if (!seen) begin
            seen <= 1'b1;
          end else begin
            seen <= 1'b0;
            if (avail_rd < req_rd || need_rd < req_rd) fits <= 1'b0;
            if (last_res) begin
              res_r <= '0;
              if (!fits || avail_rd < req_rd || need_rd < req_rd) begin
                stat_r <= STATUS_REFUSED;
                count  <= '0;
                state  <= S_OUT;
              end else begin
                state <= S_APPLY;
              end
            end else begin
              res_r <= res_r + RW'(1);
            end
          end
        end
        S_APPLY: begin
          if (!seen) begin
            seen <= 1'b1;
          end else begin
            seen <= 1'b0;
            avail[res_r] <= avail_rd - req_rd;
            if (last_res) begin
              res_r  <= '0;
              is_req <= 1'b1;
              state  <= S_SINIT;
            end else begin
              res_r <= res_r + RW'(1);
            end
          end
        end
        S_SINIT: begin
          for (int j = 0; j < MAX_RESOURCES; j++) work[j] <= avail[j];
          fin    <= '0;
          count  <= '0;
          pass   <= '0;
          scan_p <= '0;
          res_r  <= '0;
          fits   <= 1'b1;
          seen   <= 1'b0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          // One pass: find first unfinished process whose need fits work.
          if (pass == np) begin
            state <= is_req && (count != np) ? S_UNDO : S_OUT;
            stat_r <= (count == np) ? STATUS_SAFE : STATUS_UNSAFE;
            res_r <= '0;
            seen  <= 1'b0;
          end else if (CW'(scan_p) >= np || fin[scan_p]) begin
            if (CW'(scan_p) + CW'(1) >= np) begin
              // nothing found in this pass; later passes find nothing either
              pass   <= np;
            end else begin
              scan_p <= scan_p + PW'(1);
            end
            res_r <= '0;
            fits  <= 1'b1;
            seen  <= 1'b0;
          end else if (!seen) begin
            seen <= 1'b1;
          end else begin
            seen <= 1'b0;
            if (last_res) begin
              res_r <= '0;
              if (fits && !(work_rd < need_rd)) begin
                fin[scan_p] <= 1'b1;
                count <= count + CW'(1);
                state <= S_ADD;
              end else if (CW'(scan_p) + CW'(1) >= np) begin
                pass <= np;
              end else begin
                scan_p <= scan_p + PW'(1);
                fits   <= 1'b1;
              end
            end else begin
              if (work_rd < need_rd) fits <= 1'b0;
              res_r <= res_r + RW'(1);
            end
          end
        end
        S_ADD: begin
          if (!seen) begin
            seen <= 1'b1;
          end else begin
            seen <= 1'b0;
            work[res_r] <= wsum[COUNT_WIDTH] ? CMAX : wsum[COUNT_WIDTH-1:0];
            if (last_res) begin
              res_r  <= '0;
              scan_p <= '0;
              fits   <= 1'b1;
              pass   <= pass + CW'(1);
              state  <= S_SCAN;
            end else begin
              res_r <= res_r + RW'(1);
            end
          end
        end
        S_UNDO: begin
          if (!seen) begin
            seen <= 1'b1;
          end else begin
            seen <= 1'b0;
            avail[res_r] <= avail_rd + req_rd;
            if (last_res) begin
              res_r <= '0;
              state <= S_OUT;
            end else begin
              res_r <= res_r + RW'(1);
            end
          end
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/bankers_resource_request_check_core.sv =====
// Top level: banker's algorithm request checker with config registers.
// Loads pass through a four-entry command queue.
// A request check or safety scan steps through the matrix memory one element
// at a time; items are handled one at a time.
// After rst the matrices are cleared entry by entry, during which at most four
// items queue up; configuration writes are always accepted.
module bankers_resource_request_check_core import brc_pkg::*; #(
  parameter int MAX_PROCESSES = 16,
  parameter int MAX_RESOURCES = 8,
  parameter int COUNT_WIDTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [3:0]  process,
  input  logic [2:0]  resource,
  input  logic [15:0] amount,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  finished_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [4:0] num_processes;
  logic [3:0] num_resources;
  logic       cmd_valid, cmd_take;
  brc_cmd_t   cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_processes <= 5'(MAX_PROCESSES);
      num_resources <= 4'(MAX_RESOURCES);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NUM_PROCESSES) num_processes <= cfg_data[4:0];
      if (cfg_index == CFG_NUM_RESOURCES) num_resources <= cfg_data[3:0];
    end
  end

  brc_front #(.MAX_PROCESSES(MAX_PROCESSES), .MAX_RESOURCES(MAX_RESOURCES)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .process(process), .resource(resource), .amount(amount),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  brc_engine #(.MAX_PROCESSES(MAX_PROCESSES), .MAX_RESOURCES(MAX_RESOURCES),
               .COUNT_WIDTH(COUNT_WIDTH)) u_engine (
    .clk(clk), .rst(rst), .num_processes(num_processes), .num_resources(num_resources),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .finished_count(finished_count)
  );

endmodule
